// File: design/sst_pkg.sv
// Shared types and fixed constants of the sliding sum-threshold flagger.
// Depends on nothing; every other design file refers to it by scoped names.
package sst_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned THRESH_W = 24;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 24'hFFFFFF;

  // One input request as it sits in the input register.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       masked;
    logic                       last_in_line;
  } sst_item_t;

  // Control passed from the window core to the output drain.
  typedef struct packed {
    logic load;
    logic line_end;
  } sst_ctl_t;

endpackage

// File: design/sliding_sum_threshold_flagger.sv
// Sliding sum-threshold flagger: each step passes through the input register, then the drain register, to the results.
// Throughput one request per cycle while the output drain has room; a line end of n pending
// samples holds the input while the output drain hands the flush out.
// Reset (rst_n low, synchronous) empties the window and drain and sets the
// threshold to its maximum; the stored sample values are not cleared.
module sliding_sum_threshold_flagger #(
  parameter int unsigned WINDOW = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [sst_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                          in_masked,
  input  logic                          in_last_in_line,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_flag,
  output logic                          out_line_end,
  input  logic                          cfg_wr_en,
  input  logic [sst_pkg::THRESH_W-1:0]  cfg_wr_data
);

  localparam int unsigned CNT_W = $clog2(WINDOW + 1);

  // Threshold register. The user writes it only while no line is in progress; the block does not enforce this.
  logic [sst_pkg::THRESH_W-1:0] threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= sst_pkg::THRESH_RESET;
    end else if (cfg_wr_en) begin
      threshold_r <= cfg_wr_data;
    end
  end

  // Input register. A request sits here until the output drain has room for
  // whatever this sample produces; the window core then consumes it in the
  // same cycle. Because the drain reports room when its final result is being
  // taken, a steady stream moves through at one request per cycle while results are taken and no flush drains.
  logic               s1_valid_r;
  sst_pkg::sst_item_t s1_item_r;
  logic               s1_go;
  logic               free;

  assign s1_go    = s1_valid_r && free;
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.sample       <= in_sample;
      s1_item_r.masked       <= in_masked;
      s1_item_r.last_in_line <= in_last_in_line;
    end
  end

  // The window core updates the running sum and count, tests the full window
  // and produces the flags of every sample that leaves on this step.
  sst_pkg::sst_ctl_t ctl;
  logic [WINDOW-1:0] flags;
  logic [CNT_W-1:0]  count;

  sst_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (s1_go),
    .item      (s1_item_r),
    .threshold (threshold_r),
    .ctl       (ctl),
    .flags     (flags),
    .count     (count)
  );

  // The drain registers those flags and presents them one result per cycle while out_ready is high,
  // oldest sample first, with line_end on the final result of a line.
  sst_drain #(
    .WINDOW (WINDOW)
  ) u_drain (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .flags        (flags),
    .count        (count),
    .free         (free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_flag     (out_flag),
    .out_line_end (out_line_end)
  );

  // The last sample of a line always produces at least one result.
  a_line_end_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_item_r.last_in_line) |=> (out_valid && u_drain.out_valid))
    else $error("line end produced no result");

  // Input is refused only while a request waits in the input register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && !free))
    else $error("input refused without a waiting request");

  // A waiting request holds its contents until the core takes it.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("waiting request lost or changed");

endmodule

// File: design/sst_window.sv
// Window core: pending samples, running sum, unmasked count and the threshold test.
// Depends on sst_pkg for the item and control types and the widths.
module sst_window #(
  parameter int unsigned WINDOW = 8,
  localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1,
  localparam int unsigned CNT_W = $clog2(WINDOW + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           go,
  input  sst_pkg::sst_item_t             item,
  input  logic [sst_pkg::THRESH_W-1:0]   threshold,
  output sst_pkg::sst_ctl_t              ctl,
  output logic [WINDOW-1:0]              flags,
  output logic [CNT_W-1:0]               count
);

  localparam int unsigned SUM_W  = sst_pkg::SAMPLE_W + $clog2(WINDOW);
  localparam int unsigned PROD_W = sst_pkg::THRESH_W + CNT_W;
  localparam int unsigned SW     = sst_pkg::SAMPLE_W;

  logic [WINDOW-1:0][SW-1:0] samp_r, samp_w, samp_nxt;
  logic [WINDOW-1:0]         mask_r, mask_w, mask_nxt;
  logic [WINDOW-1:0]         pend_r, pend_w, pend_h, pend_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_t, sum_nxt, add_v, sub_v;
  logic [CNT_W-1:0]          cnt_r, cnt_t, cnt_nxt;
  logic [IDX_W-1:0]          fill_r, fill_nxt;
  logic [CNT_W-1:0]          fill_t;
  logic                      full;
  logic [SUM_W-1:0]          mag;
  logic [PROD_W-1:0]         prod;
  logic                      hit;

  always_comb begin
    // Place the new sample at the first free slot.
    for (int i = 0; i < WINDOW; i++) begin
      if (IDX_W'(i) == fill_r) begin
        samp_w[i] = item.sample;
        mask_w[i] = item.masked;
        pend_w[i] = 1'b0;
      end else begin
        samp_w[i] = samp_r[i];
        mask_w[i] = mask_r[i];
        pend_w[i] = pend_r[i];
      end
    end

    add_v  = item.masked ? '0 : SUM_W'(item.sample);
    sum_t  = sum_r + add_v;
    cnt_t  = cnt_r + CNT_W'(!item.masked);
    fill_t = CNT_W'(fill_r) + CNT_W'(1);
    full   = (fill_t == CNT_W'(WINDOW));

    // Mean test without a division: |sum| > threshold * count.
    mag  = sum_t[SUM_W-1] ? SUM_W'(-sum_t) : SUM_W'(sum_t);
    prod = PROD_W'(threshold) * PROD_W'(cnt_t);
    hit  = full && (cnt_t != '0) && (PROD_W'(mag) > prod);

    pend_h = hit ? {WINDOW{1'b1}} : pend_w;
    flags  = mask_w | pend_h;

    sub_v = mask_w[0] ? '0 : SUM_W'(signed'(samp_w[0]));

    ctl.load     = go;
    ctl.line_end = item.last_in_line;

    if (item.last_in_line) begin
      // Line end: flush everything pending and start a clean line.
      count    = fill_t;
      samp_nxt = samp_w;
      mask_nxt = '0;
      pend_nxt = '0;
      sum_nxt  = '0;
      cnt_nxt  = '0;
      fill_nxt = '0;
    end else if (full) begin
      // Full window: the oldest sample leaves and the rest move down.
      count    = CNT_W'(1);
      samp_nxt = samp_w >> SW;
      mask_nxt = mask_w >> 1;
      pend_nxt = pend_h >> 1;
      sum_nxt  = sum_t - sub_v;
      cnt_nxt  = cnt_t - CNT_W'(!mask_w[0]);
      fill_nxt = IDX_W'(WINDOW - 1);
    end else begin
      count    = '0;
      samp_nxt = samp_w;
      mask_nxt = mask_w;
      pend_nxt = pend_w;
      sum_nxt  = sum_t;
      cnt_nxt  = cnt_t;
      fill_nxt = fill_t[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      pend_r <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
      fill_r <= '0;
    end else if (go) begin
      mask_r <= mask_nxt;
      pend_r <= pend_nxt;
      sum_r  <= sum_nxt;
      cnt_r  <= cnt_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      samp_r <= samp_nxt;
    end
  end

endmodule

// File: design/sst_drain.sv
// Output drain: holds the flags of one step and hands them out one per cycle while out_ready is high.
// Depends on sst_pkg for the control type.
module sst_drain #(
  parameter int unsigned WINDOW = 8,
  localparam int unsigned CNT_W = $clog2(WINDOW + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sst_pkg::sst_ctl_t ctl,
  input  logic [WINDOW-1:0] flags,
  input  logic [CNT_W-1:0]  count,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_flag,
  output logic              out_line_end
);

  logic [WINDOW-1:0] flags_r, flags_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              end_r, end_nxt;

  assign out_valid    = (cnt_r != '0);
  assign out_flag     = flags_r[0];
  assign out_line_end = end_r && (cnt_r == CNT_W'(1));
  // The buffer can take a new step once its last pending result leaves.
  assign free         = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ready);

  always_comb begin
    flags_nxt = flags_r;
    cnt_nxt   = cnt_r;
    end_nxt   = end_r;
    if (ctl.load) begin
      flags_nxt = flags;
      cnt_nxt   = count;
      end_nxt   = ctl.line_end;
    end else if (out_valid && out_ready) begin
      flags_nxt = flags_r >> 1;
      cnt_nxt   = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      end_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      end_r <= end_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flags_r <= flags_nxt;
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the sliding sum-threshold flagger: a window scoreboard
// predicts every flag from the accepted requests. Depends on sst_pkg and the top level.
module tb;

  localparam int WINDOW       = 8;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 6;
  localparam int RANDOM_PHASES = 5;
  localparam int ITEMS_PER_PHASE = 30;

  localparam logic signed [sst_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
  localparam logic signed [sst_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

  // One result as the block hands it out.
  typedef struct packed {
    logic flag;
    logic line_end;
  } flag_result_t;

  // Tracks the pending window of the current line and queues the flags that the
  // block must produce, oldest first.
  class window_flag_scoreboard;
    logic [sst_pkg::THRESH_W-1:0]      threshold;
    logic signed [sst_pkg::SAMPLE_W-1:0] win_sample[WINDOW];
    bit                                win_masked[WINDOW];
    bit                                win_hit[WINDOW];
    longint                            sum;
    int                                count;
    int                                fill;
    flag_result_t                      expected_flags[$];
    int                                mismatches;

    function new();
      threshold  = sst_pkg::THRESH_RESET;
      mismatches = 0;
      clear_line();
    endfunction

    function void clear_line();
      for (int i = 0; i < WINDOW; i++) begin
        win_sample[i] = '0;
        win_masked[i] = 1'b0;
        win_hit[i]    = 1'b0;
      end
      sum   = 0;
      count = 0;
      fill  = 0;
    endfunction

    function void note_sample(logic signed [sst_pkg::SAMPLE_W-1:0] s, logic m, logic l);
      int     slot;
      longint mag;
      flag_result_t r;
      slot = (fill >= WINDOW) ? WINDOW - 1 : fill;
      win_sample[slot] = s;
      win_masked[slot] = m;
      win_hit[slot]    = 1'b0;
      fill = slot + 1;
      if (!m) begin
        sum += s;
        count++;
      end
      if (fill == WINDOW) begin
        mag = (sum < 0) ? -sum : sum;
        if (count > 0 && mag > longint'(threshold) * count) begin
          for (int i = 0; i < WINDOW; i++) win_hit[i] = 1'b1;
        end
      end
      if (l) begin
        for (int i = 0; i < fill; i++) begin
          r.flag     = win_masked[i] | win_hit[i];
          r.line_end = (i + 1 == fill);
          expected_flags.push_back(r);
        end
        clear_line();
      end else if (fill == WINDOW) begin
        r.flag     = win_masked[0] | win_hit[0];
        r.line_end = 1'b0;
        expected_flags.push_back(r);
        if (!win_masked[0]) begin
          sum -= win_sample[0];
          count--;
        end
        for (int i = 1; i < WINDOW; i++) begin
          win_sample[i-1] = win_sample[i];
          win_masked[i-1] = win_masked[i];
          win_hit[i-1]    = win_hit[i];
        end
        win_sample[WINDOW-1] = '0;
        win_masked[WINDOW-1] = 1'b0;
        win_hit[WINDOW-1]    = 1'b0;
        fill = WINDOW - 1;
      end
    endfunction

    function void check_flag(logic flag, logic line_end);
      flag_result_t want;
      if (expected_flags.size() == 0) begin
        $error("unexpected result: flag %0b line_end %0b", flag, line_end);
        mismatches++;
        return;
      end
      want = expected_flags.pop_front();
      if (flag !== want.flag) begin
        $error("flag: expected %0b, actual %0b", want.flag, flag);
        mismatches++;
      end
      if (line_end !== want.line_end) begin
        $error("line_end: expected %0b, actual %0b", want.line_end, line_end);
        mismatches++;
      end
    endfunction
  endclass

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic signed [sst_pkg::SAMPLE_W-1:0] in_sample;
  logic                                in_masked;
  logic                                in_last_in_line;
  logic                                out_valid;
  logic                                out_ready;
  logic                                out_flag;
  logic                                out_line_end;
  logic                                cfg_wr_en;
  logic [sst_pkg::THRESH_W-1:0]        cfg_wr_data;

  window_flag_scoreboard flag_board = new();

  // When set, neither side of the bench inserts gaps, so the block runs flat out.
  bit steady_flow = 1'b0;
  int quiet_cycles = 0;

  sliding_sum_threshold_flagger #(
    .WINDOW(WINDOW)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample      (in_sample),
    .in_masked      (in_masked),
    .in_last_in_line(in_last_in_line),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_flag       (out_flag),
    .out_line_end   (out_line_end),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Gap length used by both sides: mostly none, otherwise a random gap, now and then a
  // long pause, and never anything while the steady flow phase is running.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sample values are mostly placed around the threshold so that the mean test
  // lands on both sides of the limit; the rest are extremes or plain noise.
  function automatic logic signed [sst_pkg::SAMPLE_W-1:0] make_sample(int unsigned thr,
                                                                      bit neg);
    int r;
    int base;
    int v;
    logic [31:0] noise;
    r = $urandom_range(0, 99);
    if (r < 8) return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
    if (r < 28) begin
      noise = $urandom;
      return noise[sst_pkg::SAMPLE_W-1:0];
    end
    base = (thr > 8388607) ? 8388607 : int'(thr);
    v = base - base / 4 - 4 + int'($urandom_range(0, base / 2 + 8));
    if (neg) v = -v;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[sst_pkg::SAMPLE_W-1:0];
  endfunction

  // Presents one request after a random gap and holds it until the block takes
  // it. The valid line only drops when a gap is actually wanted, so back-to-back
  // requests keep it high across the boundary.
  task automatic send_sample(logic signed [sst_pkg::SAMPLE_W-1:0] s, logic m, logic l);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_sample       <= s;
    in_masked       <= m;
    in_last_in_line <= l;
    do @(posedge clk); while (!in_ready);
    flag_board.note_sample(s, m, l);
  endtask

  // Withdraws the input and waits until every predicted result has come out,
  // then lets the pipeline settle so that the block is truly idle.
  task automatic wait_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (flag_board.expected_flags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // The register has no read-back, so the scoreboard simply takes the new value
  // once the write edge has passed.
  task automatic write_threshold(logic [sst_pkg::THRESH_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    flag_board.threshold = value;
  endtask

  // Result side: ready is held high for short bursts and dropped for gaps of the
  // same shape as on the request side.
  initial begin : result_sink
    int hold;
    hold = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (steady_flow || !out_ready) begin
        out_ready <= 1'b1;
        hold = $urandom_range(0, 7);
      end else begin
        hold = pick_gap();
        if (hold > 0) begin
          out_ready <= 1'b0;
          hold--;
        end
      end
    end
  end

  // Every accepted result is compared against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid && out_ready) begin
      flag_board.check_flag(out_flag, out_line_end);
    end
  end

  // Watchdog: a long stretch with no transfer accepted on either side means the
  // block has hung, whatever the stimulus is doing.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned thr;
    int          sent;
    int          len;
    int          r;
    bit          neg;

    in_valid        = 1'b0;
    in_sample       = '0;
    in_masked       = 1'b0;
    in_last_in_line = 1'b0;
    out_ready       = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    rst_n           = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The threshold is still at its reset maximum here. A line of one sample and
    // a short line must both come straight through with only their own flags.
    send_sample(SAMPLE_MAX, 1'b0, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0, 1'b0);
    send_sample(24'sd123, 1'b1, 1'b0);
    send_sample(24'sd5, 1'b0, 1'b1);
    wait_until_drained();

    // With a zero threshold the window holds zeros until the final sample tips the
    // sum over zero; the whole window is then flagged on the flush of a line
    // exactly one window long.
    write_threshold('0);
    repeat (WINDOW - 1) send_sample('0, 1'b0, 1'b0);
    send_sample(24'sd1, 1'b0, 1'b1);
    wait_until_drained();

    // Negative sums: the first window sits exactly on the limit and must pass,
    // which lets its oldest sample out in steady state. A large masked sample in
    // the middle must stay out of both the sum and the count. The last sample
    // pushes the second window just past the limit.
    write_threshold(24'd100);
    repeat (3) send_sample(-24'sd100, 1'b0, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1, 1'b0);
    repeat (4) send_sample(-24'sd100, 1'b0, 1'b0);
    send_sample(-24'sd101, 1'b0, 1'b1);
    wait_until_drained();

    // Random phases, each with its own threshold: zero, the maximum, a low value
    // where hits are common and a fully random one. One phase runs without gaps.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       thr = 0;
        1:       thr = sst_pkg::THRESH_RESET;
        3:       thr = $urandom_range(0, 4000000);
        default: thr = $urandom_range(0, 16777215);
      endcase
      steady_flow = (phase == 2);
      write_threshold(thr[sst_pkg::THRESH_W-1:0]);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        if (r < 15) len = $urandom_range(1, WINDOW - 1);
        else if (r < 85) len = $urandom_range(WINDOW, 20);
        else len = $urandom_range(21, 40);
        neg = $urandom_range(0, 1);
        for (int i = 0; i < len; i++) begin
          send_sample(make_sample(thr, neg), $urandom_range(0, 99) < 15, i == len - 1);
        end
        sent += len;
      end
      wait_until_drained();
    end

    if (flag_board.mismatches == 0 && flag_board.expected_flags.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
